// File: rtl/cqf_pkg.sv
`timescale 1ns / 1ps
package cqf_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int DATA_W = 32;
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2,
      OP_DUMP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EMIT
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  data_out;
      logic [OCC_W-1:0]          occupancy;
      logic                      last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;        // accept a push and load its reply
      logic reply_empty; // accept pop, peek or dump on an empty queue
      logic start_read;  // accept pop, peek or dump and read the head entry
      logic emit;        // load the read word into the output register
      logic advance;     // read the next entry of a dump
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic rem_zero;
   } dp_stat_type;

endpackage

// File: rtl/cqf_dpath.sv
`timescale 1ns / 1ps
module cqf_dpath
   import cqf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              csr_write,
   input  logic [CAP_W-1:0]  csr_data,
   input  ctl_cmd_type       cmd,
   output dp_stat_type       stat,
   output rsp_type           rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [IDX_W-1:0]  head_ff, tail_ff, scan_ff;
   logic              empty_ff;
   logic [CNT_W-1:0]  rem_ff;
   op_type            op_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              full;
   logic [CNT_W-1:0]  held;
   logic [IDX_W-1:0]  head_next, tail_next, scan_next, rd_addr;
   logic              rd_en;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(i) + CNT_W'(1);
      if (inc == cap) begin
         return '0;
      end
      return IDX_W'(inc);
   endfunction

   assign head_next = next_slot(head_ff, cap_ff);
   assign tail_next = next_slot(tail_ff, cap_ff);
   assign scan_next = next_slot(scan_ff, cap_ff);

   assign full = !empty_ff && (head_ff == tail_ff);

   always_comb begin
      if (empty_ff) begin
         held = '0;
      end else if (head_ff == tail_ff) begin
         held = cap_ff;
      end else if (tail_ff > head_ff) begin
         held = CNT_W'(tail_ff) - CNT_W'(head_ff);
      end else begin
         // The sum may wrap in CNT_W bits; the true count still fits.
         held = CNT_W'(tail_ff) + cap_ff - CNT_W'(head_ff);
      end
   end

   always_comb begin
      if (csr_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (32'(csr_data) > 32'(DEPTH)) begin
         cap_in = CNT_W'(DEPTH);
      end else begin
         cap_in = CNT_W'(csr_data);
      end
   end

   assign rd_en   = cmd.start_read || cmd.advance;
   assign rd_addr = cmd.advance ? scan_next : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         mem[tail_ff] <= req_data.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CNT_W'(DEPTH);
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (csr_write) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         if (cmd.push && !full) begin
            tail_ff  <= tail_next;
            empty_ff <= 1'b0;
         end
         if (cmd.emit && op_ff == OP_POP) begin
            head_ff  <= head_next;
            empty_ff <= (head_next == tail_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         scan_ff <= head_ff;
         op_ff   <= req_data.op;
         rem_ff  <= (req_data.op == OP_DUMP) ? held - CNT_W'(1) : '0;
      end else if (cmd.advance) begin
         scan_ff <= scan_next;
         rem_ff  <= rem_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.push) begin
         rsp_in.status    = full ? STAT_FULL : STAT_OK;
         rsp_in.data_out  = req_data.push_value;
         rsp_in.occupancy = full ? OCC_W'(held) : OCC_W'(held + CNT_W'(1));
         rsp_in.last      = 1'b1;
      end else if (cmd.reply_empty) begin
         rsp_in.status    = STAT_EMPTY;
         rsp_in.data_out  = '0;
         rsp_in.occupancy = '0;
         rsp_in.last      = 1'b1;
      end else if (cmd.emit) begin
         rsp_in.status    = STAT_OK;
         rsp_in.data_out  = rd_data_ff;
         rsp_in.occupancy = (op_ff == OP_POP) ? OCC_W'(held - CNT_W'(1)) : OCC_W'(held);
         rsp_in.last      = (rem_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data      = rsp_ff;
   assign stat.empty    = empty_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

// File: rtl/cqf_ctrl.sv
`timescale 1ns / 1ps
module cqf_ctrl
   import cqf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  op_type       req_op,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  dp_stat_type  stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;
   logic      load_out;
   logic      accept;

   // The output register can take a new transaction when it is empty or drains now.
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && slot_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      load_out = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_PUSH) begin
                  cmd.push = 1'b1;
                  load_out = 1'b1;
               end else if (stat.empty) begin
                  cmd.reply_empty = 1'b1;
                  load_out        = 1'b1;
               end else begin
                  cmd.start_read = 1'b1;
                  state_in       = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               load_out = 1'b1;
               if (stat.rem_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
      endcase
   end

   assign out_valid_in = load_out || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// File: rtl/circular_queue_fifo.sv
// Push, and any operation on an empty queue, returns its transaction the cycle after acceptance.
// Pop and peek return theirs through the registered entry memory read and then the output register.
// Dump returns one transaction per stored entry, one per cycle while rsp_stall is low.
// A new request waits until the previous one is in the output register and it drains.
// Synchronous reset empties the queue and sets the capacity to DEPTH; entries are not cleared.
`timescale 1ns / 1ps
module circular_queue_fifo
   import cqf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   cqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cqf_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/cqf_checker.sv
`timescale 1ns / 1ps
module cqf_checker
   import cqf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stall,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  rsp_type  rsp_data
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped its valid");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled response payload changed");

   // A request is never taken while the output register is blocked.
   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("request accepted while output register is stalled");

   a_empty_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_EMPTY |->
         rsp_data.data_out == '0 && rsp_data.occupancy == '0 && rsp_data.last)
      else $error("empty reply carries data or occupancy");

   a_full_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_FULL |-> rsp_data.last)
      else $error("full reply is not a single transaction");

endmodule

bind circular_queue_fifo cqf_checker u_cqf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
